// ----- design/thb_pkg.sv -----
// thb_pkg: shared constants and register index codes for the temporal
// history blend. Used by temporal_history_blend; depends on nothing.
`timescale 1ns / 1ps

package thb_pkg;

    // fixed-point unity and half in Q1.15
    localparam logic [15:0] ONE_Q15  = 16'd32768;
    localparam logic [15:0] HALF_Q15 = 16'd16384;
    localparam logic [15:0] ROUND_Q15 = 16'd16384;

    // Rec.709 weights in Q0.16
    localparam logic [15:0] LUMA_WR = 16'd13933;
    localparam logic [15:0] LUMA_WG = 16'd46871;
    localparam logic [15:0] LUMA_WB = 16'd4732;
    localparam logic [15:0] LUMA_ROUND = 16'd32768;

    // level = (diff*1000 + mag*256 + 1280) / 2560, done as >>9 then /5
    localparam logic [9:0]  DEPTH_GAIN = 10'd1000;
    localparam logic [10:0] LEVEL_BIAS = 11'd1280;
    localparam logic [17:0] DIV5_RECIP = 18'd209716;   // ceil(2^20 / 5)
    localparam int          DIV5_SHIFT = 20;

    // configuration register reset values
    localparam logic        ENABLE_RESET    = 1'b1;
    localparam logic [15:0] LIMIT_RESET     = 16'd26;
    localparam logic [15:0] MIN_BLEND_RESET = 16'd1638;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE    = 2'd0,
        REG_LIMIT     = 2'd1,
        REG_MIN_BLEND = 2'd2
    } cfg_reg_t;

endpackage

// ----- design/temporal_history_blend.sv -----
// temporal_history_blend: per-pixel history/current color blend with
// disocclusion and confidence, as one deep pipeline. Depends on thb_pkg.
// Throughput: one pixel per clock while the output is not stalled; the 32-bit
// motion square root is spread over eight stages at two root bits each, the input
// stage forms the motion squares and luma products, later multiplies get their own stages.
// A stalled output beat freezes the whole pipeline; nothing is dropped.
// Reset clears all stage valid bits and loads the register defaults.
`timescale 1ns / 1ps

module temporal_history_blend (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [thb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [thb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [15:0]                       history_red,
    input  logic [15:0]                       history_green,
    input  logic [15:0]                       history_blue,
    input  logic [15:0]                       current_red,
    input  logic [15:0]                       current_green,
    input  logic [15:0]                       current_blue,
    input  logic signed [15:0]                motion_x,
    input  logic signed [15:0]                motion_y,
    input  logic [15:0]                       depth_now,
    input  logic [15:0]                       depth_before,
    input  logic [15:0]                       blend_alpha,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [15:0]                       out_red,
    output logic [15:0]                       out_green,
    output logic [15:0]                       out_blue,
    output logic [15:0]                       disocclusion_level,
    output logic [15:0]                       confidence_level,
    output logic [15:0]                       luma_before,
    output logic [15:0]                       luma_now
);
    import thb_pkg::*;

    localparam int ST_IN    = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_SQ0   = 3;
    localparam int SQ_STG   = 8;
    localparam int ST_SQL   = ST_SQ0 + SQ_STG - 1;
    localparam int ST_NUM   = ST_SQL + 1;
    localparam int ST_QUO   = ST_NUM + 1;
    localparam int ST_LVL   = ST_QUO + 1;
    localparam int ST_CPR   = ST_LVL + 1;
    localparam int ST_CONF  = ST_CPR + 1;
    localparam int ST_APR   = ST_CONF + 1;
    localparam int ST_W     = ST_APR + 1;
    localparam int ST_DPR   = ST_W + 1;
    localparam int ST_OUT   = ST_DPR + 1;
    localparam int NS       = ST_OUT;

    typedef struct packed {
        logic [16:0] rem;
        logic [15:0] root;
    } sq_t;

    typedef struct packed {
        logic [2:0][15:0] hist;
        logic [2:0][15:0] cur;
        logic [15:0]      alpha;
        logic [15:0]      diff;
        logic [30:0]      sqx;
        logic [30:0]      sqy;
        logic [2:0][31:0] lpb;
        logic [2:0][31:0] lpn;
        logic [15:0]      luma_b;
        logic [15:0]      luma_n;
        logic [31:0]      rad;
        logic [16:0]      rem;
        logic [15:0]      root;
        logic [17:0]      n1;
        logic [15:0]      t2;
        logic [35:0]      qprod;
        logic [15:0]      level;
        logic [15:0]      t1;
        logic             forced;
        logic [31:0]      cprod;
        logic [15:0]      conf;
        logic [31:0]      aprod;
        logic [15:0]      w;
        logic [2:0][33:0] dprod;
        logic [2:0][15:0] col;
    } pipe_t;

    logic        enable_reg;
    logic [15:0] limit_reg;
    logic [15:0] min_blend_reg;
    logic [NS:1] v_reg;
    pipe_t       pipe_reg  [1:NS];
    pipe_t       pipe_next [1:NS];
    logic        adv;

    // one restoring square-root step: brings in two radicand bits
    function automatic sq_t sqrt_iter(input logic [16:0] rem, input logic [15:0] root,
                                      input logic [1:0] pair);
        logic [18:0] cur;
        logic [18:0] trial;
        sq_t         res;
        cur   = {rem, pair};
        trial = {1'b0, root[15:0], 2'b01};
        if (cur >= trial)
        begin
            res.rem  = 17'(cur - trial);
            res.root = {root[14:0], 1'b1};
        end
        else
        begin
            res.rem  = cur[16:0];
            res.root = {root[14:0], 1'b0};
        end
        return res;
    endfunction

    function automatic logic [15:0] luma_sum(input logic [2:0][31:0] p);
        logic [33:0] sum;
        sum = 34'(p[0]) + 34'(p[1]) + 34'(p[2]) + 34'(LUMA_ROUND);
        return (|sum[33:32]) ? 16'hFFFF : sum[31:16];
    endfunction

    assign adv      = !(v_reg[NS] && out_stall);
    assign in_stall = !adv;

    always_comb
    begin
        logic signed [31:0] sqx_full;
        logic signed [31:0] sqy_full;
        logic [26:0]        num;
        logic [15:0]        lv;
        logic [31:0]        csum;
        logic [31:0]        asum;
        logic [15:0]        tw;
        logic signed [16:0] dval;
        logic signed [33:0] pr;
        logic signed [34:0] total;
        sq_t                sa;
        sq_t                sb;

        for (int k = 2; k <= NS; k++)
        begin
            pipe_next[k] = pipe_reg[k-1];
        end

        // input stage: squares, depth difference, luma products
        pipe_next[ST_IN] = '0;
        sqx_full = motion_x * motion_x;
        sqy_full = motion_y * motion_y;
        pipe_next[ST_IN].hist  = {history_blue, history_green, history_red};
        pipe_next[ST_IN].cur   = {current_blue, current_green, current_red};
        pipe_next[ST_IN].alpha = blend_alpha;
        pipe_next[ST_IN].diff  = (depth_now > depth_before) ? depth_now - depth_before
                                                            : depth_before - depth_now;
        pipe_next[ST_IN].sqx   = sqx_full[30:0];
        pipe_next[ST_IN].sqy   = sqy_full[30:0];
        pipe_next[ST_IN].lpb[0] = 32'(history_red)   * 32'(LUMA_WR);
        pipe_next[ST_IN].lpb[1] = 32'(history_green) * 32'(LUMA_WG);
        pipe_next[ST_IN].lpb[2] = 32'(history_blue)  * 32'(LUMA_WB);
        pipe_next[ST_IN].lpn[0] = 32'(current_red)   * 32'(LUMA_WR);
        pipe_next[ST_IN].lpn[1] = 32'(current_green) * 32'(LUMA_WG);
        pipe_next[ST_IN].lpn[2] = 32'(current_blue)  * 32'(LUMA_WB);

        pipe_next[ST_SUM].rad    = 32'(pipe_reg[ST_SUM-1].sqx) + 32'(pipe_reg[ST_SUM-1].sqy);
        pipe_next[ST_SUM].rem    = '0;
        pipe_next[ST_SUM].root   = '0;
        pipe_next[ST_SUM].luma_b = luma_sum(pipe_reg[ST_SUM-1].lpb);
        pipe_next[ST_SUM].luma_n = luma_sum(pipe_reg[ST_SUM-1].lpn);

        // square root, two root bits per stage, radicand shifts out at the top
        for (int j = 0; j < SQ_STG; j++)
        begin
            sa = sqrt_iter(pipe_reg[ST_SQ0+j-1].rem, pipe_reg[ST_SQ0+j-1].root,
                           pipe_reg[ST_SQ0+j-1].rad[31:30]);
            sb = sqrt_iter(sa.rem, sa.root, pipe_reg[ST_SQ0+j-1].rad[29:28]);
            pipe_next[ST_SQ0+j].rem  = sb.rem;
            pipe_next[ST_SQ0+j].root = sb.root;
            pipe_next[ST_SQ0+j].rad  = {pipe_reg[ST_SQ0+j-1].rad[27:0], 4'b0};
        end

        // root is the motion magnitude from here on
        num = 27'(pipe_reg[ST_NUM-1].diff) * 27'(DEPTH_GAIN)
            + 27'({pipe_reg[ST_NUM-1].root, 8'b0}) + 27'(LEVEL_BIAS);
        pipe_next[ST_NUM].n1 = num[26:9];
        pipe_next[ST_NUM].t2 = (pipe_reg[ST_NUM-1].root >= 16'd256) ? HALF_Q15
            : ONE_Q15 - 16'({pipe_reg[ST_NUM-1].root[7:0], 6'b0});

        pipe_next[ST_QUO].qprod = 36'(pipe_reg[ST_QUO-1].n1) * 36'(DIV5_RECIP);

        lv = pipe_reg[ST_LVL-1].qprod[DIV5_SHIFT +: 16];
        pipe_next[ST_LVL].level  = enable_reg ? lv : '0;
        pipe_next[ST_LVL].t1     = (pipe_next[ST_LVL].level >= 16'd128) ? '0
            : ONE_Q15 - 16'({pipe_next[ST_LVL].level[6:0], 8'b0});
        pipe_next[ST_LVL].forced = enable_reg && (pipe_next[ST_LVL].level > limit_reg);

        pipe_next[ST_CPR].cprod = 32'(pipe_reg[ST_CPR-1].t1) * 32'(pipe_reg[ST_CPR-1].t2);

        csum = pipe_reg[ST_CONF-1].cprod + 32'(ROUND_Q15);
        pipe_next[ST_CONF].conf = enable_reg ? csum[30:15] : ONE_Q15;

        pipe_next[ST_APR].aprod = 32'(pipe_reg[ST_APR-1].alpha) * 32'(pipe_reg[ST_APR-1].conf);

        asum = pipe_reg[ST_W-1].aprod + 32'(ROUND_Q15);
        tw   = asum[30:15];
        if (pipe_reg[ST_W-1].forced)
        begin
            pipe_next[ST_W].w = ONE_Q15;
        end
        else
        begin
            pipe_next[ST_W].w = (tw < min_blend_reg) ? min_blend_reg : tw;
        end

        for (int c = 0; c < 3; c++)
        begin
            dval = $signed({1'b0, pipe_reg[ST_DPR-1].cur[c]})
                 - $signed({1'b0, pipe_reg[ST_DPR-1].hist[c]});
            pr   = dval * $signed({1'b0, pipe_reg[ST_DPR-1].w});
            pipe_next[ST_DPR].dprod[c] = pr;
        end

        // history*1 + delta*w with w in Q1.15, rounded, clamped to the unsigned 16-bit range
        for (int c = 0; c < 3; c++)
        begin
            total = $signed({4'b0, pipe_reg[ST_OUT-1].hist[c], 15'b0})
                  + $signed({pipe_reg[ST_OUT-1].dprod[c][33], pipe_reg[ST_OUT-1].dprod[c]})
                  + $signed(35'(ROUND_Q15));
            if (total[34])
            begin
                pipe_next[ST_OUT].col[c] = '0;
            end
            else if (|total[33:31])
            begin
                pipe_next[ST_OUT].col[c] = 16'hFFFF;
            end
            else
            begin
                pipe_next[ST_OUT].col[c] = total[30:15];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            enable_reg    <= ENABLE_RESET;
            limit_reg     <= LIMIT_RESET;
            min_blend_reg <= MIN_BLEND_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_ENABLE:    enable_reg    <= cfg_data[0];
                    REG_LIMIT:     limit_reg     <= cfg_data;
                    REG_MIN_BLEND: min_blend_reg <= cfg_data;
                    default:       ;
                endcase
            end
            if (adv)
            begin
                v_reg <= {v_reg[NS-1:1], in_valid};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 1; k <= NS; k++)
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    assign out_valid          = v_reg[NS];
    assign out_red            = pipe_reg[NS].col[0];
    assign out_green          = pipe_reg[NS].col[1];
    assign out_blue           = pipe_reg[NS].col[2];
    assign disocclusion_level = pipe_reg[NS].level;
    assign confidence_level   = pipe_reg[NS].conf;
    assign luma_before        = pipe_reg[NS].luma_b;
    assign luma_now           = pipe_reg[NS].luma_n;

`ifndef NO_ASSERTIONS
    // remainder of the root must stay within 2*root
    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_SQL] |-> (pipe_reg[ST_SQL].rem <= {pipe_reg[ST_SQL].root, 1'b0}))
        else $error("square root remainder out of range");

    // the divide-by-five level never reaches the top bit
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_LVL] |-> (pipe_reg[ST_LVL].level[15] == 1'b0))
        else $error("disocclusion level out of range");

    a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (confidence_level <= ONE_Q15))
        else $error("confidence above one");

    a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !enable_reg) |->
            (disocclusion_level == '0 && confidence_level == ONE_Q15))
        else $error("disocclusion disabled but level or confidence not neutral");

    // a forced blend leaves exactly the current color
    a_forced: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[ST_DPR] && pipe_reg[ST_DPR].forced && adv) |=>
            (pipe_reg[ST_OUT].col == pipe_reg[ST_OUT].cur))
        else $error("forced blend did not select current color");
`endif

endmodule
